[src/assert_macros.svh]
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define AAVR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");

// checked on every clock edge, reset included
`define AAVR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("%m: check failed");

`endif

[src/aavr_pkg.sv]
package aavr_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned SqrtSteps   = 24;
  localparam int unsigned DivSteps    = 15;
  localparam int unsigned Latency     = 45;

  localparam int unsigned CordW = 32;
  localparam int unsigned AngW  = 25;
  localparam int unsigned RadW  = 48;
  localparam int unsigned RootW = 24;
  localparam int unsigned RemW  = 26;
  localparam int unsigned NumW  = 40;
  localparam int unsigned DenW  = 25;

  localparam logic signed [CordW-1:0] CordicOne = 32'sd652032874;
  localparam logic signed [AngW-1:0]  Deg90     = 25'sd2949120;
  localparam logic signed [AngW-1:0]  Deg180    = 25'sd5898240;
  localparam logic signed [15:0]      Q14One    = 16'sd16384;

  // word passed along the cordic / square root chain
  typedef struct packed {
    logic signed [15:0]       ax;
    logic signed [15:0]       ay;
    logic signed [15:0]       az;
    logic signed [15:0]       vx;
    logic signed [15:0]       vy;
    logic signed [15:0]       vz;
    logic signed [CordW-1:0]  cx;
    logic signed [CordW-1:0]  cy;
    logic signed [AngW-1:0]   cz;
    logic                     neg_cos;
    logic [RadW-1:0]          sq_v;
    logic [RemW-1:0]          sq_rem;
    logic [RootW-1:0]         sq_root;
  } rot_t;

  // word passed along the divider chain, three lanes for x, y, z
  typedef struct packed {
    logic signed [15:0]       vx;
    logic signed [15:0]       vy;
    logic signed [15:0]       vz;
    logic signed [15:0]       c14;
    logic                     nz;
    logic [DenW-1:0]          den;
    logic [2:0][NumW-1:0]     rem;
    logic [2:0][DivSteps-1:0] quo;
    logic [2:0]               ovf;
    logic [2:0]               neg;
  } div_t;

  function automatic logic signed [AngW-1:0] atan_at(input logic [3:0] idx);
    logic signed [AngW-1:0] r;
    unique case (idx)
      4'd0:    r = 25'sd1474560;
      4'd1:    r = 25'sd870484;
      4'd2:    r = 25'sd459940;
      4'd3:    r = 25'sd233473;
      4'd4:    r = 25'sd117189;
      4'd5:    r = 25'sd58652;
      4'd6:    r = 25'sd29333;
      4'd7:    r = 25'sd14667;
      4'd8:    r = 25'sd7334;
      4'd9:    r = 25'sd3667;
      4'd10:   r = 25'sd1833;
      4'd11:   r = 25'sd917;
      4'd12:   r = 25'sd458;
      4'd13:   r = 25'sd229;
      4'd14:   r = 25'sd115;
      default: r = 25'sd57;
    endcase
    return r;
  endfunction

endpackage

[src/aavr_rot_cell.sv]
module aavr_rot_cell import aavr_pkg::*; #(
  parameter int unsigned Step = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  rot_t data_i,
  output logic valid_o,
  output rot_t data_o
);

  rot_t            data_d, data_q;
  logic            valid_q;
  logic [RemW+1:0] rem_sh, trial;

  always_comb begin
    data_d = data_i;
    rem_sh = {data_i.sq_rem, data_i.sq_v[RadW-1 -: 2]};
    trial  = {2'b00, data_i.sq_root, 2'b01};
    if (Step < CordicSteps) begin
      // zero angle takes the positive direction
      if (!data_i.cz[AngW-1]) begin
        data_d.cx = data_i.cx - (data_i.cy >>> Step);
        data_d.cy = data_i.cy + (data_i.cx >>> Step);
        data_d.cz = data_i.cz - atan_at(4'(Step));
      end else begin
        data_d.cx = data_i.cx + (data_i.cy >>> Step);
        data_d.cy = data_i.cy - (data_i.cx >>> Step);
        data_d.cz = data_i.cz + atan_at(4'(Step));
      end
    end
    if (Step < SqrtSteps) begin
      data_d.sq_v = data_i.sq_v << 2;
      if (rem_sh >= trial) begin
        data_d.sq_rem  = RemW'(rem_sh - trial);
        data_d.sq_root = {data_i.sq_root[RootW-2:0], 1'b1};
      end else begin
        data_d.sq_rem  = RemW'(rem_sh);
        data_d.sq_root = {data_i.sq_root[RootW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[src/aavr_div_cell.sv]
module aavr_div_cell import aavr_pkg::*; #(
  parameter int unsigned Bit = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  div_t data_i,
  output logic valid_o,
  output div_t data_o
);

  div_t            data_d, data_q;
  logic            valid_q;
  logic [NumW-1:0] divisor;

  always_comb begin
    data_d  = data_i;
    divisor = NumW'(data_i.den) << Bit;
    for (int k = 0; k < 3; k++) begin
      if (data_i.rem[k] >= divisor) begin
        data_d.rem[k]      = data_i.rem[k] - divisor;
        data_d.quo[k][Bit] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[src/axis_angle_vector_rotation.sv]
// Axis-angle vector rotation.
// An item is taken at a rising edge with start high; busy is always low, so a
// new item may be given in every cycle. Each item carries an axis, an angle in
// 1/64 degree and a Q4.12 vector. The block builds the unit quaternion in
// Q1.14 (rot_w/x/y/z) and the rotated vector in Q5.12 (out_x/y/z).
// done_o is high for one cycle, and the result words are valid while it is high.
// Throughput is one item per cycle. Each item passes through the input register,
// the chain of 24 square root cells (the 16 cordic steps run alongside the
// first 16 of them), the rounding register, the 15 divider cells, the
// quaternion register, the two Hamilton product stages and the output register.
// Items come out in the order they went in; there is no hold-off on the
// output side, so the receiver must take each word in its strobe cycle.
// Reset clears all valid bits: items in flight are dropped and done_o stays
// low until a new item has gone through.
module axis_angle_vector_rotation import aavr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] axis_x_i,
  input  logic signed [15:0] axis_y_i,
  input  logic signed [15:0] axis_z_i,
  input  logic signed [15:0] angle_i,
  input  logic signed [15:0] vec_x_i,
  input  logic signed [15:0] vec_y_i,
  input  logic signed [15:0] vec_z_i,
  output logic               done_o,
  output logic signed [15:0] rot_w_o,
  output logic signed [15:0] rot_x_o,
  output logic signed [15:0] rot_y_o,
  output logic signed [15:0] rot_z_o,
  output logic signed [16:0] out_x_o,
  output logic signed [16:0] out_y_o,
  output logic signed [16:0] out_z_o
);

  typedef struct packed {
    logic signed [15:0] ax, ay, az, ang, vx, vy, vz;
    logic [31:0]        sqx, sqy, sqz;
  } in_t;

  typedef struct packed {
    logic signed [15:0] ax, ay, az, vx, vy, vz, c14;
    logic [14:0]        s_mag;
    logic               s_neg;
    logic [RootW-1:0]   n;
  } sc_t;

  typedef struct packed {
    logic signed [15:0] qw, qx, qy, qz, vx, vy, vz;
  } qv_t;

  typedef struct packed {
    logic signed [15:0] qw, qx, qy, qz;
    logic signed [33:0] t0, t1, t2, t3;
  } tp_t;

  typedef struct packed {
    logic signed [15:0] qw, qx, qy, qz;
    logic signed [51:0] r1, r2, r3;
  } rp_t;

  function automatic logic signed [15:0] sat14(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v > 17'sd16384) r = Q14One;
    else if (v < -17'sd16384) r = -Q14One;
    else r = 16'(v);
    return r;
  endfunction

  function automatic logic signed [16:0] round_out(input logic signed [51:0] v);
    logic signed [51:0] s;
    logic signed [23:0] o;
    logic signed [16:0] r;
    s = v + (52'sd1 <<< 27);
    o = 24'(s >>> 28);
    if (o > 24'sd65535) r = 17'sd65535;
    else if (o < -24'sd65536) r = -17'sd65536;
    else r = 17'(o);
    return r;
  endfunction

  in_t  a_d, a_q;
  rot_t b_d;
  sc_t  c_d, c_q;
  div_t d_d;
  qv_t  e_d, e_q;
  tp_t  f_d, f_q;
  rp_t  g_d, g_q;
  logic va_q, vc_q, ve_q, vf_q, vg_q, vh_q;

  rot_t rot_w [SqrtSteps+1];
  logic rot_v [SqrtSteps+1];
  div_t div_w [DivSteps+1];
  logic div_v [DivSteps+1];

  logic signed [15:0] out_w_q, out_qx_q, out_qy_q, out_qz_q;
  logic signed [16:0] ox_q, oy_q, oz_q;

  assign busy = 1'b0;

  // squares of the axis
  always_comb begin
    a_d.ax  = axis_x_i;
    a_d.ay  = axis_y_i;
    a_d.az  = axis_z_i;
    a_d.ang = angle_i;
    a_d.vx  = vec_x_i;
    a_d.vy  = vec_y_i;
    a_d.vz  = vec_z_i;
    a_d.sqx = 32'($signed(32'(axis_x_i)) * $signed(32'(axis_x_i)));
    a_d.sqy = 32'($signed(32'(axis_y_i)) * $signed(32'(axis_y_i)));
    a_d.sqz = 32'($signed(32'(axis_z_i)) * $signed(32'(axis_z_i)));
  end

  // length sum and half angle range reduction
  always_comb begin
    logic signed [AngW-1:0] z;
    z = AngW'($signed({a_q.ang, 8'h00}));
    b_d.ax      = a_q.ax;
    b_d.ay      = a_q.ay;
    b_d.az      = a_q.az;
    b_d.vx      = a_q.vx;
    b_d.vy      = a_q.vy;
    b_d.vz      = a_q.vz;
    b_d.cx      = CordicOne;
    b_d.cy      = '0;
    b_d.neg_cos = 1'b0;
    b_d.cz      = z;
    if (z > Deg90) begin
      b_d.cz      = Deg180 - z;
      b_d.neg_cos = 1'b1;
    end else if (z < -Deg90) begin
      b_d.cz      = -Deg180 - z;
      b_d.neg_cos = 1'b1;
    end
    b_d.sq_v    = {a_q.sqx + a_q.sqy + a_q.sqz, 16'h0000};
    b_d.sq_rem  = '0;
    b_d.sq_root = '0;
  end

  assign rot_w[0] = b_d;
  assign rot_v[0] = va_q;

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_rot
    aavr_rot_cell #(.Step(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (rot_v[i]),
      .data_i  (rot_w[i]),
      .valid_o (rot_v[i+1]),
      .data_o  (rot_w[i+1])
    );
  end

  // rounding of sine and cosine to q1.14
  always_comb begin
    logic signed [CordW:0] xs, ys;
    logic signed [15:0]    cr, sr;
    xs = (CordW+1)'(rot_w[SqrtSteps].cx) + 33'sd32768;
    ys = (CordW+1)'(rot_w[SqrtSteps].cy) + 33'sd32768;
    cr = sat14(17'(xs >>> 16));
    sr = sat14(17'(ys >>> 16));
    c_d.ax    = rot_w[SqrtSteps].ax;
    c_d.ay    = rot_w[SqrtSteps].ay;
    c_d.az    = rot_w[SqrtSteps].az;
    c_d.vx    = rot_w[SqrtSteps].vx;
    c_d.vy    = rot_w[SqrtSteps].vy;
    c_d.vz    = rot_w[SqrtSteps].vz;
    c_d.c14   = rot_w[SqrtSteps].neg_cos ? -cr : cr;
    c_d.s_mag = sr[15] ? 15'(-sr) : 15'(sr);
    c_d.s_neg = sr[15];
    c_d.n     = rot_w[SqrtSteps].sq_root;
  end

  // divider setup: rounded quotient is floor((512*num + n) / (2*n))
  always_comb begin
    logic [15:0] mag [3];
    logic [30:0] num;
    logic [NumW-1:0] big;
    mag[0] = c_q.ax[15] ? 16'(-c_q.ax) : 16'(c_q.ax);
    mag[1] = c_q.ay[15] ? 16'(-c_q.ay) : 16'(c_q.ay);
    mag[2] = c_q.az[15] ? 16'(-c_q.az) : 16'(c_q.az);
    d_d.vx  = c_q.vx;
    d_d.vy  = c_q.vy;
    d_d.vz  = c_q.vz;
    d_d.c14 = c_q.c14;
    d_d.nz  = (c_q.n != '0);
    d_d.den = {c_q.n, 1'b0};
    d_d.quo = '0;
    big     = {d_d.den, 15'h0000};
    d_d.neg = {c_q.az[15] ^ c_q.s_neg, c_q.ay[15] ^ c_q.s_neg, c_q.ax[15] ^ c_q.s_neg};
    for (int k = 0; k < 3; k++) begin
      num        = 31'(mag[k]) * 31'(c_q.s_mag);
      d_d.rem[k] = {num, 9'h000} + NumW'(c_q.n);
      // quotient of 2^15 or more is clamped anyway
      d_d.ovf[k] = (d_d.rem[k] >= big);
    end
  end

  assign div_w[0] = d_d;
  assign div_v[0] = vc_q;

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    aavr_div_cell #(.Bit(DivSteps - 1 - i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_v[i]),
      .data_i  (div_w[i]),
      .valid_o (div_v[i+1]),
      .data_o  (div_w[i+1])
    );
  end

  // quaternion from the quotients, zero axis gives a zero vector part
  always_comb begin
    logic [DivSteps-1:0] qm;
    logic signed [15:0]  qs [3];
    for (int k = 0; k < 3; k++) begin
      if (div_w[DivSteps].ovf[k] || div_w[DivSteps].quo[k] > 15'd16384) qm = 15'd16384;
      else qm = div_w[DivSteps].quo[k];
      if (!div_w[DivSteps].nz) qs[k] = '0;
      else if (div_w[DivSteps].neg[k]) qs[k] = -16'(qm);
      else qs[k] = 16'(qm);
    end
    e_d.qw = div_w[DivSteps].c14;
    e_d.qx = qs[0];
    e_d.qy = qs[1];
    e_d.qz = qs[2];
    e_d.vx = div_w[DivSteps].vx;
    e_d.vy = div_w[DivSteps].vy;
    e_d.vz = div_w[DivSteps].vz;
  end

  // t = q * (0, v)
  always_comb begin
    f_d.qw = e_q.qw;
    f_d.qx = e_q.qx;
    f_d.qy = e_q.qy;
    f_d.qz = e_q.qz;
    f_d.t0 = -(34'(e_q.qx) * 34'(e_q.vx)) - 34'(e_q.qy) * 34'(e_q.vy)
             - 34'(e_q.qz) * 34'(e_q.vz);
    f_d.t1 = 34'(e_q.qw) * 34'(e_q.vx) + 34'(e_q.qy) * 34'(e_q.vz)
             - 34'(e_q.qz) * 34'(e_q.vy);
    f_d.t2 = 34'(e_q.qw) * 34'(e_q.vy) - 34'(e_q.qx) * 34'(e_q.vz)
             + 34'(e_q.qz) * 34'(e_q.vx);
    f_d.t3 = 34'(e_q.qw) * 34'(e_q.vz) + 34'(e_q.qx) * 34'(e_q.vy)
             - 34'(e_q.qy) * 34'(e_q.vx);
  end

  // r = t * conj(q), vector part only
  always_comb begin
    g_d.qw = f_q.qw;
    g_d.qx = f_q.qx;
    g_d.qy = f_q.qy;
    g_d.qz = f_q.qz;
    g_d.r1 = -(52'(f_q.t0) * 52'(f_q.qx)) + 52'(f_q.t1) * 52'(f_q.qw)
             - 52'(f_q.t2) * 52'(f_q.qz) + 52'(f_q.t3) * 52'(f_q.qy);
    g_d.r2 = -(52'(f_q.t0) * 52'(f_q.qy)) + 52'(f_q.t1) * 52'(f_q.qz)
             + 52'(f_q.t2) * 52'(f_q.qw) - 52'(f_q.t3) * 52'(f_q.qx);
    g_d.r3 = -(52'(f_q.t0) * 52'(f_q.qz)) - 52'(f_q.t1) * 52'(f_q.qy)
             + 52'(f_q.t2) * 52'(f_q.qx) + 52'(f_q.t3) * 52'(f_q.qw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vc_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
      vh_q <= 1'b0;
    end else begin
      va_q <= start & ~busy;
      vc_q <= rot_v[SqrtSteps];
      ve_q <= div_v[DivSteps];
      vf_q <= ve_q;
      vg_q <= vf_q;
      vh_q <= vg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    c_q      <= c_d;
    e_q      <= e_d;
    f_q      <= f_d;
    g_q      <= g_d;
    out_w_q  <= g_q.qw;
    out_qx_q <= g_q.qx;
    out_qy_q <= g_q.qy;
    out_qz_q <= g_q.qz;
    ox_q     <= round_out(g_q.r1);
    oy_q     <= round_out(g_q.r2);
    oz_q     <= round_out(g_q.r3);
  end

  assign done_o  = vh_q;
  assign rot_w_o = out_w_q;
  assign rot_x_o = out_qx_q;
  assign rot_y_o = out_qy_q;
  assign rot_z_o = out_qz_q;
  assign out_x_o = ox_q;
  assign out_y_o = oy_q;
  assign out_z_o = oz_q;

endmodule

[src/aavr_checker.sv]
`include "assert_macros.svh"

module aavr_checker import aavr_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input logic signed [15:0] rot_w_o,
  input logic signed [15:0] rot_x_o,
  input logic signed [15:0] rot_y_o,
  input logic signed [15:0] rot_z_o
);

  logic quat_ok;

  assign quat_ok = rot_w_o <= 16'sd16384 && rot_w_o >= -16'sd16384
                && rot_x_o <= 16'sd16384 && rot_x_o >= -16'sd16384
                && rot_y_o <= 16'sd16384 && rot_y_o >= -16'sd16384
                && rot_z_o <= 16'sd16384 && rot_z_o >= -16'sd16384;

  `AAVR_ASSERT_ALWAYS(a_never_busy, clk_i, !busy)
  `AAVR_ASSERT(a_word_follows, clk_i, rst_ni, (start && !busy) |-> ##Latency done_o)
  `AAVR_ASSERT(a_word_has_cause, clk_i, rst_ni, done_o |-> $past(start && !busy, Latency))
  `AAVR_ASSERT(a_quat_range, clk_i, rst_ni, done_o |-> quat_ok)

endmodule

bind axis_angle_vector_rotation aavr_checker u_aavr_checker (.*);

[tb/axis_angle_vector_rotation_tb.sv]
`timescale 1ns / 1ps

module axis_angle_vector_rotation_tb;
  import aavr_pkg::*;

  typedef struct {
    logic signed [15:0] w, x, y, z;
    logic signed [16:0] ox, oy, oz;
  } rotation_t;

  localparam int unsigned WatchdogLimit = 2000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] axis_x_i = '0, axis_y_i = '0, axis_z_i = '0, angle_i = '0;
  logic signed [15:0] vec_x_i = '0, vec_y_i = '0, vec_z_i = '0;
  logic               done_o;
  logic signed [15:0] rot_w_o, rot_x_o, rot_y_o, rot_z_o;
  logic signed [16:0] out_x_o, out_y_o, out_z_o;

  rotation_t expected_rotations[$];
  int unsigned n_errors = 0;
  int unsigned n_words_in = 0;
  int unsigned n_words_out = 0;
  int unsigned idle_cycles = 0;
  bit          allow_gaps = 1'b1;

  axis_angle_vector_rotation dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint atan_step(int i);
    longint t[16] = '{1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
                      7334, 3667, 1833, 917, 458, 229, 115, 57};
    return t[i];
  endfunction

  function automatic longint unit_axis(longint a, longint s, longint n);
    longint ma, ms, q;
    ma = a < 0 ? -a : a;
    ms = s < 0 ? -s : s;
    if (n == 0) return 0;
    q = (2 * ma * ms * 256 + n) / (2 * n);
    if (q > 16384) q = 16384;
    return ((a < 0) != (s < 0)) ? -q : q;
  endfunction

  function automatic void hprod(input longint a[4], input longint b[4], output longint r[4]);
    r[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
    r[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
    r[2] = a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1];
    r[3] = a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0];
  endfunction

  function automatic rotation_t predict_rotation(
      logic signed [15:0] ax, ay, az, ang, vx, vy, vz);
    rotation_t res;
    longint z, x, y, dx, dy, c, s, n;
    longint q[4], qc[4], v[4], t[4], r[4];
    bit neg_cos;
    z = longint'(ang) * 256;
    neg_cos = 1'b0;
    x = 652032874;
    y = 0;
    if (z > 2949120) begin
      z = 5898240 - z;
      neg_cos = 1'b1;
    end else if (z < -2949120) begin
      z = -5898240 - z;
      neg_cos = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    c = clip(floor_shift(x + 32768, 16), -16384, 16384);
    s = clip(floor_shift(y + 32768, 16), -16384, 16384);
    if (neg_cos) c = -c;
    n = int_sqrt((longint'(ax)*ax + longint'(ay)*ay + longint'(az)*az) << 16);
    q[0] = c;
    q[1] = unit_axis(ax, s, n);
    q[2] = unit_axis(ay, s, n);
    q[3] = unit_axis(az, s, n);
    qc[0] = q[0]; qc[1] = -q[1]; qc[2] = -q[2]; qc[3] = -q[3];
    v[0] = 0; v[1] = vx; v[2] = vy; v[3] = vz;
    hprod(q, v, t);
    hprod(t, qc, r);
    res.w = 16'(q[0]); res.x = 16'(q[1]); res.y = 16'(q[2]); res.z = 16'(q[3]);
    res.ox = 17'(clip(floor_shift(r[1] + (64'sd1 <<< 27), 28), -65536, 65535));
    res.oy = 17'(clip(floor_shift(r[2] + (64'sd1 <<< 27), 28), -65536, 65535));
    res.oz = 17'(clip(floor_shift(r[3] + (64'sd1 <<< 27), 28), -65536, 65535));
    return res;
  endfunction

  // one word in; start stays high for back-to-back words
  task automatic send_word(logic signed [15:0] ax, ay, az, ang, vx, vy, vz);
    int gap;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    axis_x_i <= ax; axis_y_i <= ay; axis_z_i <= az; angle_i <= ang;
    vec_x_i <= vx; vec_y_i <= vy; vec_z_i <= vz;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_rotations.push_back(predict_rotation(ax, ay, az, ang, vx, vy, vz));
    n_words_in++;
  endtask

  task automatic drain_pipeline();
    start <= 1'b0;
    while (expected_rotations.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_word(bit zero_axis);
    logic signed [15:0] ang;
    ang = ($urandom_range(0, 15) == 0) ? 16'($urandom)
                                       : 16'(int'($urandom_range(0, 46080)) - 23040);
    if (zero_axis)
      send_word(0, 0, 0, ang, 16'($urandom), 16'($urandom), 16'($urandom));
    else if ($urandom_range(0, 3) == 0)
      send_word(16'($urandom_range(0, 15) - 8), 16'($urandom_range(0, 15) - 8),
                16'($urandom_range(0, 15) - 8), ang,
                16'($urandom), 16'($urandom), 16'($urandom));
    else
      send_word(16'($urandom), 16'($urandom), 16'($urandom), ang,
                16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic test_directed();
    send_word(16'sd1, 0, 0, 16'sd5760, 16'sd4096, 16'sd4096, 16'sd4096);
    send_word(0, 16'sd100, 0, 16'sd5760, 16'sd4096, 0, 0);
    send_word(0, 0, 16'sd7, -16'sd5760, 0, 16'sd4096, 0);
    send_word(0, 0, 0, 16'sd11520, 16'sd4096, -16'sd4096, 16'sd1000);
    send_word(0, 0, 0, 0, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_word(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sd23040, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_word(16'sh8000, 16'sh8000, 16'sh8000, -16'sd23040, 16'sh8000, 16'sh8000, 16'sh8000);
    send_word(16'sh8000, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 16'sh8000);
    send_word(16'sh7fff, 16'sh8000, 0, 16'sh8000, 16'sh8000, 16'sh7fff, 0);
    send_word(16'sd1, 16'sd1, 16'sd1, 16'sd11521, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_word(-16'sd1, 16'sd1, 16'sd1, -16'sd11521, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_word(16'sd3, -16'sd4, 16'sd0, 16'sd1, 16'sd1, -16'sd1, 16'sd0);
    send_word(16'sd1, 0, 0, -16'sd1, 16'sh5555, 16'shaaaa, 16'sh5555);
    send_word(0, 16'sd1, 0, 16'sd23039, 16'shaaaa, 16'sh5555, 16'shaaaa);
    send_word(16'sd2, 16'sd2, 16'sd1, 16'sd11520, 16'sd4096, 16'sd8192, -16'sd12288);
    drain_pipeline();
  endtask

  task automatic test_random();
    repeat (200) send_random_word($urandom_range(0, 9) == 0);
  endtask

  // sender waits for the pipeline to empty before going on
  task automatic test_pause_until_empty();
    drain_pipeline();
    repeat (50) send_random_word(1'b0);
  endtask

  task automatic test_full_rate();
    allow_gaps = 1'b0;
    repeat (150) send_random_word($urandom_range(0, 9) == 0);
  endtask

  always @(posedge clk_i) begin
    rotation_t exp_rot;
    if (rst_ni && done_o) begin
      n_words_out++;
      if (expected_rotations.size() == 0) begin
        $error("result word with nothing expected");
        n_errors++;
      end else begin
        exp_rot = expected_rotations.pop_front();
        if (rot_w_o !== exp_rot.w) begin
          $error("rot_w exp %0d got %0d", exp_rot.w, rot_w_o); n_errors++;
        end
        if (rot_x_o !== exp_rot.x) begin
          $error("rot_x exp %0d got %0d", exp_rot.x, rot_x_o); n_errors++;
        end
        if (rot_y_o !== exp_rot.y) begin
          $error("rot_y exp %0d got %0d", exp_rot.y, rot_y_o); n_errors++;
        end
        if (rot_z_o !== exp_rot.z) begin
          $error("rot_z exp %0d got %0d", exp_rot.z, rot_z_o); n_errors++;
        end
        if (out_x_o !== exp_rot.ox) begin
          $error("out_x exp %0d got %0d", exp_rot.ox, out_x_o); n_errors++;
        end
        if (out_y_o !== exp_rot.oy) begin
          $error("out_y exp %0d got %0d", exp_rot.oy, out_y_o); n_errors++;
        end
        if (out_z_o !== exp_rot.oz) begin
          $error("out_z exp %0d got %0d", exp_rot.oz, out_z_o); n_errors++;
        end
      end
    end
  end

  // cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("timeout waiting for a word");
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    test_pause_until_empty();
    test_full_rate();
    drain_pipeline();
    repeat (Latency + 10) @(posedge clk_i);
    $display("sent %0d words, checked %0d results: extremes, zero axis, wrapped angles,",
             n_words_in, n_words_out);
    $display("random axes and vectors with sender gaps, a drain pause and full-rate input");
    if (n_errors == 0 && expected_rotations.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (expected_rotations.size() != 0)
        $error("%0d results never arrived", expected_rotations.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
